### hw/rtl/xidp_pkg.sv
// Shared types and constants for the XID parameter frame parser.
package xidp_pkg;

  localparam int MAX_VALUE_BYTES_DEF = 4;

  localparam logic [7:0] FORMAT_ID = 8'h82;
  localparam logic [7:0] GROUP_ID  = 8'h80;

  localparam logic [7:0] PID_CLASSES  = 8'd2;
  localparam logic [7:0] PID_OPTIONAL = 8'd3;
  localparam logic [7:0] PID_RX_LEN   = 8'd6;
  localparam logic [7:0] PID_WINDOW   = 8'd8;
  localparam logic [7:0] PID_TIMER    = 8'd9;
  localparam logic [7:0] PID_RETRIES  = 8'd10;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_BAD_FORMAT = 3'd1;
  localparam logic [2:0] ST_BAD_GROUP  = 3'd2;
  localparam logic [2:0] ST_BAD_LENGTH = 3'd3;
  localparam logic [2:0] ST_TRUNCATED  = 3'd4;

  localparam int W_NO_ABM   = 0;
  localparam int W_DUPLEX   = 1;
  localparam int W_NO_REJ   = 2;
  localparam int W_MODULO   = 3;
  localparam int W_EXTADDR  = 4;
  localparam int W_TEST     = 5;
  localparam int W_FCS      = 6;
  localparam int W_SYNC     = 7;
  localparam int W_PARTIAL  = 8;
  localparam int W_WINDOW   = 9;
  localparam int W_MISMATCH = 10;
  localparam int WARN_W     = 11;

  localparam int CLS_ABM_BIT   = 8;
  localparam int CLS_HALF_BIT  = 13;
  localparam int CLS_FULL_BIT  = 14;
  localparam int OPT_IREJ_BIT  = 17;
  localparam int OPT_SREJ_BIT  = 18;
  localparam int OPT_MOD8_BIT  = 10;
  localparam int OPT_MOD128_BIT = 11;
  localparam int OPT_EXTADDR_BIT = 23;
  localparam int OPT_TEST_BIT  = 13;
  localparam int OPT_FCS_BIT   = 15;
  localparam int OPT_SYNC_BIT  = 1;

  localparam logic [1:0]  REJ_IMPLICIT  = 2'd1;
  localparam logic [1:0]  REJ_SELECTIVE = 2'd2;
  localparam logic [1:0]  REJ_SREJ_REJ  = 2'd3;
  localparam logic [28:0] DEF_RX_BYTES  = 29'd256;
  localparam logic [6:0]  DEF_WINDOW_8  = 7'd7;
  localparam logic [6:0]  DEF_WINDOW_128 = 7'd32;
  localparam logic [31:0] DEF_TIMER     = 32'd3000;
  localparam logic [31:0] DEF_RETRIES   = 32'd10;
  localparam logic [31:0] WIN_LIMIT_8   = 32'd8;
  localparam logic [31:0] WIN_LIMIT_128 = 32'd128;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_end;
  } beat_t;

  typedef struct packed {
    logic [2:0]        status;
    logic              duplex_mode;
    logic [1:0]        reject_mode;
    logic              seq_modulo;
    logic [28:0]       rx_info_bytes;
    logic [6:0]        rx_window;
    logic [31:0]       ack_timer_ms;
    logic [31:0]       retry_count;
    logic [WARN_W-1:0] warning_flags;
  } result_t;

endpackage

### hw/rtl/xidp_in_stage.sv
// Input register that holds one byte beat until the parser takes it.
module xidp_in_stage (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic [7:0]     data_byte,
  input  logic           frame_end,
  input  logic           take,
  output logic           beat_valid,
  output xidp_pkg::beat_t beat
);

  assign in_stall = beat_valid && !take;

  always_ff @(posedge clk) begin
    if (rst) begin
      beat_valid <= 1'b0;
    end else if (!in_stall) begin
      beat_valid <= in_valid;
    end
    if (!in_stall && in_valid) begin
      beat.data_byte <= data_byte;
      beat.frame_end <= frame_end;
    end
  end

endmodule

### hw/rtl/xidp_parser.sv
// Frame parse state and per-byte record decoding.
module xidp_parser #(
  parameter int MAX_VALUE_BYTES = xidp_pkg::MAX_VALUE_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              beat_valid,
  input  xidp_pkg::beat_t   beat,
  input  logic              out_free,
  output logic              take,
  output logic              res_valid,
  output xidp_pkg::result_t res
);

  localparam int CNT_W = $clog2(MAX_VALUE_BYTES + 1);

  typedef enum logic [2:0] {
    PH_FORMAT, PH_GROUP, PH_GLEN_HI, PH_GLEN_LO, PH_IND, PH_LEN, PH_VAL, PH_STOP
  } phase_t;

  phase_t                      phase, phase_next;
  logic [15:0]                 group_length, group_length_next;
  logic [16:0]                 byte_pos, byte_pos_next;
  logic [7:0]                  param_id, param_id_next;
  logic [CNT_W-1:0]            bytes_left, bytes_left_next;
  logic [31:0]                 accum, accum_next;
  logic                        duplex, duplex_next;
  logic [1:0]                  reject, reject_next;
  logic                        mod128, mod128_next;
  logic [28:0]                 rx_bytes, rx_bytes_next;
  logic [6:0]                  window, window_next;
  logic [31:0]                 timer, timer_next;
  logic [31:0]                 retries, retries_next;
  logic [xidp_pkg::WARN_W-1:0] warn, warn_next;
  logic [2:0]                  status, status_next;

  logic [7:0]  d;
  logic [31:0] val;
  logic [31:0] win_limit;
  logic        bit_a, bit_b;
  logic        frame_done;

  assign take       = beat_valid && (!beat.frame_end || out_free);
  assign frame_done = take && beat.frame_end;
  assign res_valid  = frame_done;
  assign d          = beat.data_byte;
  assign val        = {accum[23:0], d};
  assign win_limit  = mod128 ? xidp_pkg::WIN_LIMIT_128 : xidp_pkg::WIN_LIMIT_8;

  always_comb begin
    phase_next        = phase;
    group_length_next = group_length;
    byte_pos_next     = byte_pos;
    param_id_next     = param_id;
    bytes_left_next   = bytes_left;
    accum_next        = accum;
    duplex_next       = duplex;
    reject_next       = reject;
    mod128_next       = mod128;
    rx_bytes_next     = rx_bytes;
    window_next       = window;
    timer_next        = timer;
    retries_next      = retries;
    warn_next         = warn;
    status_next       = status;
    bit_a             = 1'b0;
    bit_b             = 1'b0;

    if (take) begin
      case (phase)
        PH_FORMAT: begin
          if (d != xidp_pkg::FORMAT_ID) begin
            status_next = xidp_pkg::ST_BAD_FORMAT;
            phase_next  = PH_STOP;
          end else begin
            phase_next = PH_GROUP;
          end
        end
        PH_GROUP: begin
          if (d != xidp_pkg::GROUP_ID) begin
            status_next = xidp_pkg::ST_BAD_GROUP;
            phase_next  = PH_STOP;
          end else begin
            phase_next = PH_GLEN_HI;
          end
        end
        PH_GLEN_HI: begin
          group_length_next = {d, 8'h00};
          phase_next        = PH_GLEN_LO;
        end
        PH_GLEN_LO: begin
          group_length_next = {group_length[15:8], d};
          byte_pos_next     = '0;
          phase_next        = PH_IND;
        end
        PH_IND: begin
          if (byte_pos >= {1'b0, group_length}) begin
            warn_next[xidp_pkg::W_MISMATCH] = 1'b1;
            phase_next = PH_STOP;
          end else begin
            param_id_next = d;
            byte_pos_next = byte_pos + 17'd1;
            phase_next    = PH_LEN;
          end
        end
        PH_LEN: begin
          byte_pos_next = byte_pos + 17'd1;
          if (d == 8'd0 || d > 8'(MAX_VALUE_BYTES)) begin
            status_next = xidp_pkg::ST_BAD_LENGTH;
            phase_next  = PH_STOP;
          end else begin
            bytes_left_next = CNT_W'(d);
            accum_next      = '0;
            phase_next      = PH_VAL;
          end
        end
        PH_VAL: begin
          byte_pos_next   = byte_pos + 17'd1;
          accum_next      = val;
          bytes_left_next = bytes_left - CNT_W'(1);
          if (bytes_left == CNT_W'(1)) begin
            phase_next = PH_IND;
            case (param_id)
              xidp_pkg::PID_CLASSES: begin
                if (!val[xidp_pkg::CLS_ABM_BIT]) warn_next[xidp_pkg::W_NO_ABM] = 1'b1;
                bit_a = val[xidp_pkg::CLS_HALF_BIT];
                bit_b = val[xidp_pkg::CLS_FULL_BIT];
                if (bit_a && !bit_b) begin
                  duplex_next = 1'b0;
                end else if (bit_b && !bit_a) begin
                  duplex_next = 1'b1;
                end else begin
                  warn_next[xidp_pkg::W_DUPLEX] = 1'b1;
                end
              end
              xidp_pkg::PID_OPTIONAL: begin
                bit_a = val[xidp_pkg::OPT_IREJ_BIT];
                bit_b = val[xidp_pkg::OPT_SREJ_BIT];
                if (bit_a && bit_b) begin
                  reject_next = xidp_pkg::REJ_SREJ_REJ;
                end else if (bit_a) begin
                  reject_next = xidp_pkg::REJ_IMPLICIT;
                end else if (bit_b) begin
                  reject_next = xidp_pkg::REJ_SELECTIVE;
                end else begin
                  warn_next[xidp_pkg::W_NO_REJ] = 1'b1;
                end
                if (val[xidp_pkg::OPT_MOD8_BIT] && !val[xidp_pkg::OPT_MOD128_BIT]) begin
                  mod128_next = 1'b0;
                end else if (val[xidp_pkg::OPT_MOD128_BIT] && !val[xidp_pkg::OPT_MOD8_BIT]) begin
                  mod128_next = 1'b1;
                end else begin
                  warn_next[xidp_pkg::W_MODULO] = 1'b1;
                end
                if (!val[xidp_pkg::OPT_EXTADDR_BIT]) warn_next[xidp_pkg::W_EXTADDR] = 1'b1;
                if (!val[xidp_pkg::OPT_TEST_BIT]) warn_next[xidp_pkg::W_TEST] = 1'b1;
                if (!val[xidp_pkg::OPT_FCS_BIT]) warn_next[xidp_pkg::W_FCS] = 1'b1;
                if (!val[xidp_pkg::OPT_SYNC_BIT]) warn_next[xidp_pkg::W_SYNC] = 1'b1;
              end
              xidp_pkg::PID_RX_LEN: begin
                rx_bytes_next = val[31:3];
                if (val[2:0] != 3'd0) warn_next[xidp_pkg::W_PARTIAL] = 1'b1;
              end
              xidp_pkg::PID_WINDOW: begin
                if (val == 32'd0 || val >= win_limit) begin
                  warn_next[xidp_pkg::W_WINDOW] = 1'b1;
                  window_next = mod128 ? xidp_pkg::DEF_WINDOW_128 : xidp_pkg::DEF_WINDOW_8;
                end else begin
                  window_next = val[6:0];
                end
              end
              xidp_pkg::PID_TIMER: begin
                timer_next = val;
              end
              xidp_pkg::PID_RETRIES: begin
                retries_next = val;
              end
              default: begin
              end
            endcase
          end
        end
        default: begin
        end
      endcase
    end

    res.status        = status_next;
    res.warning_flags = warn_next;
    if (phase_next inside {PH_FORMAT, PH_GROUP, PH_GLEN_HI, PH_GLEN_LO}) begin
      res.status = xidp_pkg::ST_TRUNCATED;
    end else if (phase_next == PH_LEN || phase_next == PH_VAL ||
                 (phase_next == PH_IND && byte_pos_next < {1'b0, group_length_next})) begin
      res.warning_flags[xidp_pkg::W_MISMATCH] = 1'b1;
    end
    res.duplex_mode   = duplex_next;
    res.reject_mode   = reject_next;
    res.seq_modulo    = mod128_next;
    res.rx_info_bytes = rx_bytes_next;
    res.rx_window     = window_next;
    res.ack_timer_ms  = timer_next;
    res.retry_count   = retries_next;
  end

  always_ff @(posedge clk) begin
    if (rst || frame_done) begin
      phase        <= PH_FORMAT;
      group_length <= '0;
      byte_pos     <= '0;
      param_id     <= '0;
      bytes_left   <= '0;
      accum        <= '0;
      duplex       <= 1'b0;
      reject       <= xidp_pkg::REJ_SELECTIVE;
      mod128       <= 1'b0;
      rx_bytes     <= xidp_pkg::DEF_RX_BYTES;
      window       <= xidp_pkg::DEF_WINDOW_8;
      timer        <= xidp_pkg::DEF_TIMER;
      retries      <= xidp_pkg::DEF_RETRIES;
      warn         <= '0;
      status       <= xidp_pkg::ST_OK;
    end else begin
      phase        <= phase_next;
      group_length <= group_length_next;
      byte_pos     <= byte_pos_next;
      param_id     <= param_id_next;
      bytes_left   <= bytes_left_next;
      accum        <= accum_next;
      duplex       <= duplex_next;
      reject       <= reject_next;
      mod128       <= mod128_next;
      rx_bytes     <= rx_bytes_next;
      window       <= window_next;
      timer        <= timer_next;
      retries      <= retries_next;
      warn         <= warn_next;
      status       <= status_next;
    end
  end

endmodule

### hw/rtl/xid_parameter_frame_parser.sv
// Top level of the XID parameter frame parser with its result register.
//
//   Channel  Direction  Handshake            Payload
//   in       input      in_valid / in_stall  data_byte, frame_end
//   out      output     out_valid / out_stall status ... warning_flags
//
// One byte beat is taken every cycle while in_stall is low; a beat passes the
// input register and the parser decodes it combinationally, and the result
// register captures that result when the beat that ends its frame is taken.
// Reset is synchronous; it clears the valid flags and returns every parser
// field to its default.
// Only a frame-end beat waits on a stalled result; other beats keep flowing.
module xid_parameter_frame_parser #(
  parameter int MAX_VALUE_BYTES = xidp_pkg::MAX_VALUE_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        frame_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic        duplex_mode,
  output logic [1:0]  reject_mode,
  output logic        seq_modulo,
  output logic [28:0] rx_info_bytes,
  output logic [6:0]  rx_window,
  output logic [31:0] ack_timer_ms,
  output logic [31:0] retry_count,
  output logic [10:0] warning_flags
);

  xidp_pkg::beat_t   beat;
  xidp_pkg::result_t res;
  xidp_pkg::result_t res_q;
  logic              beat_valid;
  logic              take;
  logic              res_valid;
  logic              out_free;

  assign out_free = !out_valid || !out_stall;

  xidp_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .data_byte  (data_byte),
    .frame_end  (frame_end),
    .take       (take),
    .beat_valid (beat_valid),
    .beat       (beat)
  );

  xidp_parser #(
    .MAX_VALUE_BYTES (MAX_VALUE_BYTES)
  ) u_parser (
    .clk        (clk),
    .rst        (rst),
    .beat_valid (beat_valid),
    .beat       (beat),
    .out_free   (out_free),
    .take       (take),
    .res_valid  (res_valid),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= res_valid;
    end
    if (out_free && res_valid) begin
      res_q <= res;
    end
  end

  assign status        = res_q.status;
  assign duplex_mode   = res_q.duplex_mode;
  assign reject_mode   = res_q.reject_mode;
  assign seq_modulo    = res_q.seq_modulo;
  assign rx_info_bytes = res_q.rx_info_bytes;
  assign rx_window     = res_q.rx_window;
  assign ack_timer_ms  = res_q.ack_timer_ms;
  assign retry_count   = res_q.retry_count;
  assign warning_flags = res_q.warning_flags;

  // The input side can only be held back by a result that is waiting.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("Input stalled without a waiting result.");

  // A frame that never reached its records carries no warnings.
  a_early_no_warn: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status == xidp_pkg::ST_TRUNCATED || status == xidp_pkg::ST_BAD_FORMAT ||
                   status == xidp_pkg::ST_BAD_GROUP)) |-> (warning_flags == '0))
    else $error("Header error reported together with warnings.");

  a_window_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (rx_window != '0))
    else $error("Result carries a zero receive window.");

endmodule

### verif/xid_parameter_frame_parser_test.sv
// Self-checking testbench for the XID parameter frame parser, with a byte-level parse predictor.
`timescale 1ns / 100ps

module xid_parameter_frame_parser_test;

  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 8;
  localparam int LONG_HOLD = 400;
  localparam int RANDOM_BEATS = 400;
  localparam int DIRECTED_ROWS = 27;
  localparam logic [10:0] NO_WARN = '0;
  localparam logic [10:0] MISMATCH_ONLY = 11'(1) << xidp_pkg::W_MISMATCH;

  typedef enum logic [2:0] {
    AT_FORMAT, AT_GROUP, AT_LEN_HI, AT_LEN_LO, AT_INDICATOR, AT_VALUE_LEN, AT_VALUE, AT_HALT
  } parse_at_t;

  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    logic        typed;
    logic [2:0]  st;
    logic [10:0] warn;
  } dir_row_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = 8'h00;
  logic        frame_end = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  status;
  logic        duplex_mode;
  logic [1:0]  reject_mode;
  logic        seq_modulo;
  logic [28:0] rx_info_bytes;
  logic [6:0]  rx_window;
  logic [31:0] ack_timer_ms;
  logic [31:0] retry_count;
  logic [10:0] warning_flags;

  parse_at_t   at;
  logic [15:0] grp_len;
  logic [16:0] grp_pos;
  logic [7:0]  cur_id;
  logic [2:0]  bytes_left;
  logic [31:0] accum;
  xidp_pkg::result_t negotiated;

  xidp_pkg::result_t awaited_params[$];
  xidp_pkg::result_t seen;
  xidp_pkg::result_t want;
  int          mismatches = 0;
  int          beats_sent = 0;
  int          cycle_count = 0;
  bit          hold_long = 1'b0;
  bit          sender_burst = 1'b0;

  dir_row_t directed_rows [DIRECTED_ROWS] = '{
    '{8'h00, 1'b1, 1'b1, xidp_pkg::ST_BAD_FORMAT, NO_WARN},
    '{xidp_pkg::FORMAT_ID, 1'b0, 1'b0, xidp_pkg::ST_OK, NO_WARN},
    '{8'h7F, 1'b1, 1'b1, xidp_pkg::ST_BAD_GROUP, NO_WARN},
    '{xidp_pkg::FORMAT_ID, 1'b0, 1'b0, xidp_pkg::ST_OK, NO_WARN},
    '{xidp_pkg::GROUP_ID, 1'b0, 1'b0, xidp_pkg::ST_OK, NO_WARN},
    '{8'h00, 1'b1, 1'b1, xidp_pkg::ST_TRUNCATED, NO_WARN},
    '{xidp_pkg::FORMAT_ID, 1'b0, 1'b0, xidp_pkg::ST_OK, NO_WARN},
    '{xidp_pkg::GROUP_ID, 1'b0, 1'b0, xidp_pkg::ST_OK, NO_WARN},
    '{8'h00, 1'b0, 1'b0, xidp_pkg::ST_OK, NO_WARN},
    '{8'h04, 1'b0, 1'b0, xidp_pkg::ST_OK, NO_WARN},
    '{xidp_pkg::PID_WINDOW, 1'b0, 1'b0, xidp_pkg::ST_OK, NO_WARN},
    '{8'h00, 1'b1, 1'b1, xidp_pkg::ST_BAD_LENGTH, NO_WARN},
    '{xidp_pkg::FORMAT_ID, 1'b0, 1'b0, xidp_pkg::ST_OK, NO_WARN},
    '{xidp_pkg::GROUP_ID, 1'b0, 1'b0, xidp_pkg::ST_OK, NO_WARN},
    '{8'h00, 1'b0, 1'b0, xidp_pkg::ST_OK, NO_WARN},
    '{8'h03, 1'b0, 1'b0, xidp_pkg::ST_OK, NO_WARN},
    '{xidp_pkg::PID_TIMER, 1'b0, 1'b0, xidp_pkg::ST_OK, NO_WARN},
    '{8'h04, 1'b0, 1'b0, xidp_pkg::ST_OK, NO_WARN},
    '{8'hFF, 1'b0, 1'b0, xidp_pkg::ST_OK, NO_WARN},
    '{8'hFF, 1'b0, 1'b0, xidp_pkg::ST_OK, NO_WARN},
    '{8'hFF, 1'b0, 1'b0, xidp_pkg::ST_OK, NO_WARN},
    '{8'hFF, 1'b1, 1'b0, xidp_pkg::ST_OK, NO_WARN},
    '{xidp_pkg::FORMAT_ID, 1'b0, 1'b0, xidp_pkg::ST_OK, NO_WARN},
    '{xidp_pkg::GROUP_ID, 1'b0, 1'b0, xidp_pkg::ST_OK, NO_WARN},
    '{8'h00, 1'b0, 1'b0, xidp_pkg::ST_OK, NO_WARN},
    '{8'h00, 1'b0, 1'b0, xidp_pkg::ST_OK, NO_WARN},
    '{8'hFF, 1'b1, 1'b1, xidp_pkg::ST_OK, MISMATCH_ONLY}
  };

  xid_parameter_frame_parser dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .data_byte(data_byte),
    .frame_end(frame_end),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status(status),
    .duplex_mode(duplex_mode),
    .reject_mode(reject_mode),
    .seq_modulo(seq_modulo),
    .rx_info_bytes(rx_info_bytes),
    .rx_window(rx_window),
    .ack_timer_ms(ack_timer_ms),
    .retry_count(retry_count),
    .warning_flags(warning_flags)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic xidp_pkg::result_t idle_result();
    xidp_pkg::result_t r;
    r.status = xidp_pkg::ST_OK;
    r.duplex_mode = 1'b0;
    r.reject_mode = xidp_pkg::REJ_SELECTIVE;
    r.seq_modulo = 1'b0;
    r.rx_info_bytes = xidp_pkg::DEF_RX_BYTES;
    r.rx_window = xidp_pkg::DEF_WINDOW_8;
    r.ack_timer_ms = xidp_pkg::DEF_TIMER;
    r.retry_count = xidp_pkg::DEF_RETRIES;
    r.warning_flags = '0;
    return r;
  endfunction

  function automatic void clear_parse();
    at = AT_FORMAT;
    grp_len = '0;
    grp_pos = '0;
    cur_id = '0;
    bytes_left = '0;
    accum = '0;
    negotiated = idle_result();
  endfunction

  function automatic void take_param(logic [7:0] id, logic [31:0] v);
    case (id)
      xidp_pkg::PID_CLASSES: begin
        if (!v[xidp_pkg::CLS_ABM_BIT]) negotiated.warning_flags[xidp_pkg::W_NO_ABM] = 1'b1;
        if (v[xidp_pkg::CLS_HALF_BIT] && !v[xidp_pkg::CLS_FULL_BIT])
          negotiated.duplex_mode = 1'b0;
        else if (v[xidp_pkg::CLS_FULL_BIT] && !v[xidp_pkg::CLS_HALF_BIT])
          negotiated.duplex_mode = 1'b1;
        else negotiated.warning_flags[xidp_pkg::W_DUPLEX] = 1'b1;
      end
      xidp_pkg::PID_OPTIONAL: begin
        if (v[xidp_pkg::OPT_IREJ_BIT] && v[xidp_pkg::OPT_SREJ_BIT])
          negotiated.reject_mode = xidp_pkg::REJ_SREJ_REJ;
        else if (v[xidp_pkg::OPT_IREJ_BIT]) negotiated.reject_mode = xidp_pkg::REJ_IMPLICIT;
        else if (v[xidp_pkg::OPT_SREJ_BIT]) negotiated.reject_mode = xidp_pkg::REJ_SELECTIVE;
        else negotiated.warning_flags[xidp_pkg::W_NO_REJ] = 1'b1;
        if (v[xidp_pkg::OPT_MOD8_BIT] && !v[xidp_pkg::OPT_MOD128_BIT])
          negotiated.seq_modulo = 1'b0;
        else if (v[xidp_pkg::OPT_MOD128_BIT] && !v[xidp_pkg::OPT_MOD8_BIT])
          negotiated.seq_modulo = 1'b1;
        else negotiated.warning_flags[xidp_pkg::W_MODULO] = 1'b1;
        if (!v[xidp_pkg::OPT_EXTADDR_BIT])
          negotiated.warning_flags[xidp_pkg::W_EXTADDR] = 1'b1;
        if (!v[xidp_pkg::OPT_TEST_BIT]) negotiated.warning_flags[xidp_pkg::W_TEST] = 1'b1;
        if (!v[xidp_pkg::OPT_FCS_BIT]) negotiated.warning_flags[xidp_pkg::W_FCS] = 1'b1;
        if (!v[xidp_pkg::OPT_SYNC_BIT]) negotiated.warning_flags[xidp_pkg::W_SYNC] = 1'b1;
      end
      xidp_pkg::PID_RX_LEN: begin
        negotiated.rx_info_bytes = v[31:3];
        if (v[2:0] != 3'd0) negotiated.warning_flags[xidp_pkg::W_PARTIAL] = 1'b1;
      end
      xidp_pkg::PID_WINDOW: begin
        if (v == 32'd0 || v >= (negotiated.seq_modulo ? xidp_pkg::WIN_LIMIT_128
                                                      : xidp_pkg::WIN_LIMIT_8)) begin
          negotiated.warning_flags[xidp_pkg::W_WINDOW] = 1'b1;
          negotiated.rx_window = negotiated.seq_modulo ? xidp_pkg::DEF_WINDOW_128
                                                       : xidp_pkg::DEF_WINDOW_8;
        end else begin
          negotiated.rx_window = v[6:0];
        end
      end
      xidp_pkg::PID_TIMER: negotiated.ack_timer_ms = v;
      xidp_pkg::PID_RETRIES: negotiated.retry_count = v;
      default: ;
    endcase
  endfunction

  // Returns 1 when the byte closes a frame, with the negotiated parameters in res.
  function automatic bit parse_byte(input logic [7:0] d, input logic last,
                                    output xidp_pkg::result_t res);
    case (at)
      AT_FORMAT: begin
        if (d != xidp_pkg::FORMAT_ID) begin
          negotiated.status = xidp_pkg::ST_BAD_FORMAT;
          at = AT_HALT;
        end else begin
          at = AT_GROUP;
        end
      end
      AT_GROUP: begin
        if (d != xidp_pkg::GROUP_ID) begin
          negotiated.status = xidp_pkg::ST_BAD_GROUP;
          at = AT_HALT;
        end else begin
          at = AT_LEN_HI;
        end
      end
      AT_LEN_HI: begin
        grp_len = {d, 8'h00};
        at = AT_LEN_LO;
      end
      AT_LEN_LO: begin
        grp_len[7:0] = d;
        grp_pos = '0;
        at = AT_INDICATOR;
      end
      AT_INDICATOR: begin
        if (grp_pos >= grp_len) begin
          negotiated.warning_flags[xidp_pkg::W_MISMATCH] = 1'b1;
          at = AT_HALT;
        end else begin
          cur_id = d;
          grp_pos = grp_pos + 17'd1;
          at = AT_VALUE_LEN;
        end
      end
      AT_VALUE_LEN: begin
        grp_pos = grp_pos + 17'd1;
        if (d < 1 || d > xidp_pkg::MAX_VALUE_BYTES_DEF) begin
          negotiated.status = xidp_pkg::ST_BAD_LENGTH;
          at = AT_HALT;
        end else begin
          bytes_left = d[2:0];
          accum = '0;
          at = AT_VALUE;
        end
      end
      AT_VALUE: begin
        grp_pos = grp_pos + 17'd1;
        accum = {accum[23:0], d};
        bytes_left = bytes_left - 3'd1;
        if (bytes_left == 3'd0) begin
          take_param(cur_id, accum);
          at = AT_INDICATOR;
        end
      end
      default: ;
    endcase
    res = negotiated;
    if (!last) return 1'b0;
    if (at <= AT_LEN_LO) begin
      negotiated.status = xidp_pkg::ST_TRUNCATED;
    end else if (at == AT_VALUE_LEN || at == AT_VALUE ||
                 (at == AT_INDICATOR && grp_pos < grp_len)) begin
      negotiated.warning_flags[xidp_pkg::W_MISMATCH] = 1'b1;
    end
    res = negotiated;
    clear_parse();
    return 1'b1;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] exp_val);
    $display("%0t: %s got %0h, expected %0h", $time, what, got, exp_val);
    mismatches++;
  endtask

  task automatic send_beat(input xidp_pkg::beat_t b, input logic typed,
                           input xidp_pkg::result_t typed_res);
    int gap;
    xidp_pkg::result_t pred;
    gap = (sender_burst || hold_long) ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b.data_byte;
    frame_end <= b.frame_end;
    do @(posedge clk); while (in_stall !== 1'b0);
    if (parse_byte(b.data_byte, b.frame_end, pred))
      awaited_params.push_back(typed ? typed_res : pred);
    beats_sent++;
  endtask

  task automatic drain_awaited();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaited_params.size() != 0) @(posedge clk);
  endtask

  task automatic build_frame(ref xidp_pkg::beat_t frame[$]);
    logic [7:0] body[$];
    logic [7:0] id;
    logic [15:0] glen;
    int len;
    int pick;
    frame.delete();
    pick = $urandom_range(0, 99);
    if (pick < 6) begin
      repeat ($urandom_range(1, 6)) body.push_back(8'($urandom));
    end else begin
      repeat ($urandom_range(0, 6)) begin
        case ($urandom_range(0, 7))
          0: id = xidp_pkg::PID_CLASSES;
          1: id = xidp_pkg::PID_OPTIONAL;
          2: id = xidp_pkg::PID_RX_LEN;
          3: id = xidp_pkg::PID_WINDOW;
          4: id = xidp_pkg::PID_TIMER;
          5: id = xidp_pkg::PID_RETRIES;
          default: id = 8'($urandom);
        endcase
        len = (id == xidp_pkg::PID_WINDOW && $urandom_range(0, 1) == 1) ? 1
              : $urandom_range(1, xidp_pkg::MAX_VALUE_BYTES_DEF);
        if ($urandom_range(0, 24) == 0)
          len = ($urandom_range(0, 1) == 1) ? 0 : $urandom_range(5, 255);
        body.push_back(id);
        body.push_back(8'(len));
        if (len >= 1 && len <= xidp_pkg::MAX_VALUE_BYTES_DEF)
          repeat (len)
            body.push_back((len == 1 && $urandom_range(0, 1) == 1) ?
                           8'($urandom_range(0, 9)) : 8'($urandom));
      end
      glen = 16'(body.size());
      case ($urandom_range(0, 11))
        0: glen = 16'($urandom);
        1: glen = glen + 16'($urandom_range(1, 3));
        2: if (glen > 0) glen = glen - 16'($urandom_range(1, (glen > 3) ? 3 : glen));
        3: repeat ($urandom_range(1, 3)) body.push_back(8'($urandom));
        4: if (body.size() > 0) repeat ($urandom_range(1, body.size())) void'(body.pop_back());
        default: ;
      endcase
      body.push_front(glen[7:0]);
      body.push_front(glen[15:8]);
      body.push_front(($urandom_range(0, 19) == 0) ? 8'($urandom) : xidp_pkg::GROUP_ID);
      body.push_front(($urandom_range(0, 19) == 0) ? 8'($urandom) : xidp_pkg::FORMAT_ID);
      if (pick < 14) begin
        len = $urandom_range(1, 3);
        while (body.size() > len) void'(body.pop_back());
      end
    end
    foreach (body[i]) frame.push_back({body[i], 1'(i == body.size() - 1)});
  endtask

  initial begin
    int quiet_left;
    int hold;
    quiet_left = 0;
    wait (rst === 1'b0);
    forever begin
      if (hold_long) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        hold_long = 1'b0;
      end
      if (quiet_left > 0) begin
        hold = 0;
        quiet_left--;
      end else begin
        hold = $urandom_range(0, 17);
        if ($urandom_range(0, 7) == 0) quiet_left = $urandom_range(3, 10);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      seen = {status, duplex_mode, reject_mode, seq_modulo, rx_info_bytes, rx_window,
              ack_timer_ms, retry_count, warning_flags};
      if (awaited_params.size() == 0) begin
        report("result with no frame pending, status", 32'(seen.status),
               32'(xidp_pkg::ST_OK));
      end else begin
        want = awaited_params.pop_front();
        if (seen.status !== want.status)
          report("status", 32'(seen.status), 32'(want.status));
        if (seen.duplex_mode !== want.duplex_mode)
          report("duplex_mode", 32'(seen.duplex_mode), 32'(want.duplex_mode));
        if (seen.reject_mode !== want.reject_mode)
          report("reject_mode", 32'(seen.reject_mode), 32'(want.reject_mode));
        if (seen.seq_modulo !== want.seq_modulo)
          report("seq_modulo", 32'(seen.seq_modulo), 32'(want.seq_modulo));
        if (seen.rx_info_bytes !== want.rx_info_bytes)
          report("rx_info_bytes", 32'(seen.rx_info_bytes), 32'(want.rx_info_bytes));
        if (seen.rx_window !== want.rx_window)
          report("rx_window", 32'(seen.rx_window), 32'(want.rx_window));
        if (seen.ack_timer_ms !== want.ack_timer_ms)
          report("ack_timer_ms", seen.ack_timer_ms, want.ack_timer_ms);
        if (seen.retry_count !== want.retry_count)
          report("retry_count", seen.retry_count, want.retry_count);
        if (seen.warning_flags !== want.warning_flags)
          report("warning_flags", 32'(seen.warning_flags), 32'(want.warning_flags));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count == CYCLE_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    xidp_pkg::beat_t frame[$];
    xidp_pkg::result_t typed_res;
    int frame_no;
    clear_parse();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    foreach (directed_rows[i]) begin
      typed_res = idle_result();
      typed_res.status = directed_rows[i].st;
      typed_res.warning_flags = directed_rows[i].warn;
      send_beat({directed_rows[i].data, directed_rows[i].last}, directed_rows[i].typed,
                typed_res);
    end
    drain_awaited();
    typed_res = idle_result();
    frame_no = 0;
    while (beats_sent < DIRECTED_ROWS + RANDOM_BEATS) begin
      build_frame(frame);
      sender_burst = ($urandom_range(0, 3) == 0);
      if (frame_no == 3) hold_long = 1'b1;
      foreach (frame[i]) send_beat(frame[i], 1'b0, typed_res);
      if (frame_no == 20) drain_awaited();
      frame_no++;
    end
    drain_awaited();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
